// ===== rtl/mor_pkg.sv =====
// Shared constants and controller/datapath interface types for the maximal ones rectangle core.
`default_nettype none

package mor_pkg;

	// fixed field widths
	localparam int AREA_W = 19;
	localparam int CFG_W  = 9;

	localparam logic [AREA_W-1:0] AREA_MAX        = '1;
	localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = 9'd256;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;     // latch the word, read the column height
		logic set_height; // update and write back the column height
		logic pop;        // pop and score against the current column
		logic flush_pop;  // pop and score at the end of a row
		logic load_top;   // refresh the top of stack from memory
		logic push;       // push (start, height)
		logic advance;    // move to the next column
		logic row_done;   // row finished, back to column zero
		logic emit;       // load the result and clear image state
	} mor_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic top_gt_h;   // stack not empty and top taller than new height
		logic depth_nz;   // stack not empty
		logic row_end;    // current column closes the row
		logic last;       // last-of-image flag of the current word
		logic score_busy; // a product is still in the scoring pipeline
	} mor_status_t;

endpackage

`default_nettype wire

// ===== rtl/mor_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mor_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/mor_ctrl.sv =====
// Controller state machine sequencing height update, stack pops, row flush and result.
`default_nettype none

module mor_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire mor_pkg::mor_status_t status,
	output mor_pkg::mor_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEIGHT,
		S_CHECK,
		S_POP_LOAD,
		S_FLUSH,
		S_FLUSH_LOAD,
		S_DRAIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_HEIGHT;
				end
			end
			S_HEIGHT: begin
				cmd.set_height = 1'b1;
				state_d        = S_CHECK;
			end
			S_CHECK: begin
				if (status.top_gt_h) begin
					cmd.pop = 1'b1;
					state_d = S_POP_LOAD;
				end else begin
					cmd.push = 1'b1;
					if (status.row_end) begin
						state_d = S_FLUSH;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			S_POP_LOAD: begin
				cmd.load_top = 1'b1;
				state_d      = S_CHECK;
			end
			S_FLUSH: begin
				if (status.depth_nz) begin
					cmd.flush_pop = 1'b1;
					state_d       = S_FLUSH_LOAD;
				end else begin
					cmd.row_done = 1'b1;
					state_d      = status.last ? S_DRAIN : S_IDLE;
				end
			end
			S_FLUSH_LOAD: begin
				cmd.load_top = 1'b1;
				state_d      = S_FLUSH;
			end
			S_DRAIN: begin
				// wait for the last product to reach the best area, and a free output slot
				if (!status.score_busy && slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mor_dp.sv =====
// Datapath: column heights, monotonic stack, scoring pipeline and best area.
`default_nettype none

module mor_dp #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write,
	input  wire logic [mor_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         pixel,
	input  wire logic                         last_of_image,
	output logic      [mor_pkg::AREA_W-1:0]   rect_area,
	input  wire mor_pkg::mor_cmd_t            cmd,
	output mor_pkg::mor_status_t              status
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1; // column index
	localparam int WW = $clog2(MAX_COLS + 1);                   // width 0..MAX_COLS
	localparam int DW = WW;                                     // stack depth
	localparam int HW = $clog2(MAX_ROWS + 1);                   // height 0..MAX_ROWS
	localparam int PW = HW + WW;                                // product
	localparam int XW = (PW > mor_pkg::AREA_W) ? PW : mor_pkg::AREA_W;
	localparam int EW = (WW > mor_pkg::CFG_W) ? WW : mor_pkg::CFG_W;
	localparam int SW = CW + HW;                                // stack entry

	localparam logic [HW-1:0] HEIGHT_MAX = HW'(MAX_ROWS);
	localparam logic [DW-1:0] DEPTH_MAX  = DW'(MAX_COLS);

	// configuration and word registers
	logic [mor_pkg::CFG_W-1:0] row_width_q;
	logic                      pix_q;
	logic                      last_q;
	logic [CW-1:0]             j_q;
	logic [CW-1:0]             column_pos_q;
	logic [MAX_COLS-1:0]       hvalid_q;
	logic [HW-1:0]             h_q;
	logic [CW-1:0]             start_q;
	logic [DW-1:0]             depth_q;
	logic [CW-1:0]             top_start_q;
	logic [HW-1:0]             top_h_q;
	logic                      score_s1;
	logic [PW-1:0]             prod_s1;
	logic [mor_pkg::AREA_W-1:0] best_q;
	logic [mor_pkg::AREA_W-1:0] rect_area_q;

	logic [HW-1:0] h_rd;
	logic [HW-1:0] h_old;
	logic [HW-1:0] h_new;
	logic [SW-1:0] stk_rd;
	logic [SW-1:0] stk_wr;
	logic [CW-1:0] stk_raddr;
	logic [EW-1:0] rw_ext;
	logic [WW-1:0] eff_w;
	logic [WW-1:0] j_plus1;
	logic [WW-1:0] score_w;
	logic [XW-1:0] prod_x;
	logic [mor_pkg::AREA_W-1:0] area_sat;
	logic          any_pop;
	logic          push_ok;

	// effective row width: zero acts as one, clamp to the column count
	always_comb begin
		rw_ext = EW'(row_width_q);
		if (rw_ext == '0) begin
			eff_w = WW'(1);
		end else if (rw_ext > EW'(MAX_COLS)) begin
			eff_w = WW'(MAX_COLS);
		end else begin
			eff_w = rw_ext[WW-1:0];
		end
	end

	assign j_plus1 = WW'(j_q) + WW'(1);

	// new column height, saturating
	assign h_old = hvalid_q[j_q] ? h_rd : '0;
	always_comb begin
		if (!pix_q) begin
			h_new = '0;
		end else if (h_old >= HEIGHT_MAX) begin
			h_new = HEIGHT_MAX;
		end else begin
			h_new = h_old + HW'(1);
		end
	end

	mor_ram #(
		.WIDTH(HW),
		.DEPTH(MAX_COLS)
	) u_heights (
		.clk   (clk),
		.we    (cmd.set_height),
		.waddr (j_q),
		.wdata (h_new),
		.raddr (column_pos_q),
		.rdata (h_rd)
	);

	// stack memory; the top entry is also held in registers
	assign any_pop   = cmd.pop || cmd.flush_pop;
	assign push_ok   = (depth_q != DEPTH_MAX);
	assign stk_wr    = {start_q, h_q};
	assign stk_raddr = CW'(depth_q - DW'(2));

	mor_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_COLS)
	) u_stack (
		.clk   (clk),
		.we    (cmd.push && push_ok),
		.waddr (depth_q[CW-1:0]),
		.wdata (stk_wr),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

	// width of the rectangle being scored
	assign score_w = cmd.flush_pop ? (j_plus1 - WW'(top_start_q)) : WW'(j_q - top_start_q);

	// saturate the product to the area range
	assign prod_x   = XW'(prod_s1);
	assign area_sat = (prod_x > XW'(mor_pkg::AREA_MAX)) ? mor_pkg::AREA_MAX
	                                                    : prod_x[mor_pkg::AREA_W-1:0];

	assign status.top_gt_h   = (depth_q != '0) && (top_h_q > h_q);
	assign status.depth_nz   = (depth_q != '0);
	assign status.row_end    = (j_plus1 >= eff_w);
	assign status.last       = last_q;
	assign status.score_busy = score_s1;

	assign rect_area = rect_area_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= mor_pkg::ROW_WIDTH_RESET;
			column_pos_q <= '0;
			hvalid_q     <= '0;
			depth_q      <= '0;
			score_s1     <= 1'b0;
			best_q       <= '0;
		end else begin
			if (cfg_write) begin
				row_width_q <= cfg_data;
			end
			if (cmd.set_height) begin
				hvalid_q[j_q] <= 1'b1;
			end
			if (cmd.push && push_ok) begin
				depth_q <= depth_q + DW'(1);
			end else if (any_pop) begin
				depth_q <= depth_q - DW'(1);
			end
			if (cmd.advance) begin
				column_pos_q <= j_plus1[CW-1:0];
			end else if (cmd.row_done) begin
				column_pos_q <= '0;
			end
			score_s1 <= any_pop;
			if (score_s1 && (area_sat > best_q)) begin
				best_q <= area_sat;
			end
			// end of image: clear everything but the row width
			if (cmd.emit) begin
				hvalid_q     <= '0;
				depth_q      <= '0;
				column_pos_q <= '0;
				best_q       <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q  <= pixel;
			last_q <= last_of_image;
			j_q    <= column_pos_q;
		end
		if (cmd.set_height) begin
			h_q     <= h_new;
			start_q <= j_q;
		end
		if (any_pop) begin
			start_q <= top_start_q;
			prod_s1 <= PW'(top_h_q) * PW'(score_w);
		end
		if (cmd.push && push_ok) begin
			top_start_q <= start_q;
			top_h_q     <= h_q;
		end else if (cmd.load_top) begin
			top_start_q <= stk_rd[SW-1:HW];
			top_h_q     <= stk_rd[HW-1:0];
		end
		if (cmd.emit) begin
			rect_area_q <= best_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/maximal_ones_rectangle_core.sv =====
// Maximal all-ones rectangle core: top level joining controller and datapath.
// A word is accepted and its column height updated; each stack entry it pops is
// followed by a stack memory read that refreshes the top, and then it is pushed.
// A word that ends a row then flushes the stack, with a refresh after each entry.
// On the last word of an image a drain state then loads the area for output once
// the scoring pipeline is empty; the input stays stalled until then, and a result
// still stalled at the output delays this. Throughput: one word in flight at a time.
// Reset: asynchronous, active low; heights read as zero through per-column valid bits.
`default_nettype none

module maximal_ones_rectangle_core #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [mor_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       pixel,
	input  wire logic                       last_of_image,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [mor_pkg::AREA_W-1:0] rect_area
);

	mor_pkg::mor_cmd_t    cmd;
	mor_pkg::mor_status_t status;

	mor_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	mor_dp #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.pixel         (pixel),
		.last_of_image (last_of_image),
		.rect_area     (rect_area),
		.cmd           (cmd),
		.status        (status)
	);

	// never pop an empty stack
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop || cmd.flush_pop) |-> status.depth_nz)
		else $error("stack pop while empty");

	// the result is taken only once the scoring pipeline is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !status.score_busy)
		else $error("result taken while a score is pending");

	// an accepted word keeps the input stalled while it is worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepting a word");

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire
